// ----- rtl/moving_speed_statistics_top_macros.svh -----
// Assertion macros for the moving speed statistics block
`ifndef MOVING_SPEED_STATISTICS_TOP_MACROS_SVH
`define MOVING_SPEED_STATISTICS_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Check that an expression holds on every clock edge outside reset
`define MSS_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("mss: invariant violated");

// Check that a condition implies a consequence on the same edge
`define MSS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mss: same-cycle implication violated");

// Check that a condition implies a consequence on the next edge
`define MSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mss: next-cycle implication violated");

`else

`define MSS_ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define MSS_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define MSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/mss_pkg.sv -----
// Shared widths, defaults and controller/datapath interface types
`default_nettype none

package mss_pkg;

    // Field widths fixed by the interface
    localparam int SPD_W   = 16;
    localparam int TS_W    = 32;
    localparam int THR_W   = 16;
    localparam int SUM_W   = 32;
    localparam int WSUM_W  = 64;
    localparam int PROD_W  = TS_W + SPD_W;
    localparam int MEAN_W  = 16;

    // Default significant bits of speed and timestamp
    localparam int SPEED_BITS_DEF = 16;
    localparam int TIME_BITS_DEF  = 32;

    // One quotient bit per division step
    localparam int DIV_STEPS = WSUM_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_item;   // latch an accepted transaction, form the step
        logic mul;         // multiply step by speed, update time totals
        logic acc;         // add product into the weighted sum
        logic div_load;    // prime the divider
        logic div_step;    // one restoring division step
        logic finish;      // round, clip, load result, clear track
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic item_last;   // current transaction closes the track
    } t_dp_stat;

endpackage

`default_nettype wire

// ----- rtl/mss_ctrl.sv -----
// Controller state machine: sequencing, division count and output valid
`default_nettype none

module mss_ctrl
    import mss_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_MUL   = 6'b000010,
        S_ACC   = 6'b000100,
        S_LOAD  = 6'b001000,
        S_DIV   = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state               r_state, n_state;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic                 r_out_valid, n_out_valid;
    logic                 out_free;
    logic                 accept;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign accept      = i_in_valid && (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // Next state, counter and commands
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = i_stat.item_last ? S_LOAD : S_IDLE;
            end
            S_LOAD: begin
                o_cmd.div_load = 1'b1;
                n_cnt          = '0;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // hold the result until the output register is free
                if (out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Set on a new result, drop when the transaction is taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.finish) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/mss_dp.sv -----
// Datapath: track state, accumulators, restoring divider and result register
`default_nettype none

module mss_dp
    import mss_pkg::*;
#(
    parameter int SPEED_BITS = SPEED_BITS_DEF,
    parameter int TIME_BITS  = TIME_BITS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [THR_W-1:0] i_cfg_wdata,
    input  wire logic [SPD_W-1:0] i_speed,
    input  wire logic [TS_W-1:0]  i_timestamp,
    input  wire logic             i_last,
    input  wire t_dp_cmd          i_cmd,
    output t_dp_stat              o_stat,
    output logic [SUM_W-1:0]      o_stopped_seconds,
    output logic [SUM_W-1:0]      o_moving_seconds,
    output logic [MEAN_W-1:0]     o_mean_moving_speed,
    output logic                  o_saturated
);

    localparam logic [SPD_W-1:0] SPEED_MASK = (SPEED_BITS >= SPD_W) ? {SPD_W{1'b1}}
                                            : SPD_W'((64'd1 << SPEED_BITS) - 64'd1);
    localparam logic [TS_W-1:0]  TIME_MASK  = (TIME_BITS >= TS_W) ? {TS_W{1'b1}}
                                            : TS_W'((64'd1 << TIME_BITS) - 64'd1);

    // Configuration and track state
    logic [THR_W-1:0]  r_threshold;
    logic              r_have_prev;
    logic [SPD_W-1:0]  r_prev_speed;
    logic [TS_W-1:0]   r_prev_time;
    logic [SUM_W-1:0]  r_stopped;
    logic [SUM_W-1:0]  r_moving;
    logic [WSUM_W-1:0] r_wsum;
    logic              r_clip;

    // Per-transaction working registers
    logic              r_last;
    logic [TS_W-1:0]   r_step;
    logic [SPD_W-1:0]  r_chg_speed;
    logic              r_mov;
    logic [PROD_W-1:0] r_prod;

    // Divider
    logic [WSUM_W-1:0] r_div;
    logic [SUM_W-1:0]  r_rem;

    // Result register
    logic [SUM_W-1:0]  r_res_stopped;
    logic [SUM_W-1:0]  r_res_moving;
    logic [MEAN_W-1:0] r_res_mean;
    logic              r_res_sat;

    logic [SPD_W-1:0]  speed_m;
    logic [TS_W-1:0]   time_m;
    logic [TS_W-1:0]   step_c;
    logic [SUM_W:0]    stop_sum, mov_sum;
    logic [WSUM_W:0]   wsum_sum;
    logic [SUM_W:0]    rem_sh;
    logic [SUM_W:0]    divisor;
    logic              div_ge;
    logic [SUM_W:0]    rem_sub;
    logic              round_up;
    logic [MEAN_W:0]   q_rnd;
    logic              mean_clip;
    logic [MEAN_W-1:0] mean_c;

    assign o_stat.item_last = r_last;

    // Form the interval length; a backwards step counts as zero
    assign speed_m = i_speed & SPEED_MASK;
    assign time_m  = i_timestamp & TIME_MASK;
    assign step_c  = (time_m >= r_prev_time) ? (time_m - r_prev_time) : '0;

    // Saturating time totals and weighted sum
    assign stop_sum = {1'b0, r_stopped} + {1'b0, r_step};
    assign mov_sum  = {1'b0, r_moving} + {1'b0, r_step};
    assign wsum_sum = {1'b0, r_wsum} + (WSUM_W + 1)'(r_prod);

    // Restoring division step: shift in the next dividend bit
    assign rem_sh  = {r_rem, r_div[WSUM_W-1]};
    assign divisor = {1'b0, r_moving};
    assign div_ge  = (rem_sh >= divisor);
    assign rem_sub = div_ge ? (rem_sh - divisor) : rem_sh;

    // Round half up, then clip the mean to its field
    assign round_up  = ({r_rem, 1'b0} >= divisor);
    assign q_rnd     = {1'b0, r_div[MEAN_W-1:0]} + (MEAN_W + 1)'(round_up);
    assign mean_clip = (r_moving != '0) && ((|r_div[WSUM_W-1:MEAN_W]) || q_rnd[MEAN_W]);
    assign mean_c    = (r_moving == '0) ? '0
                     : (mean_clip ? {MEAN_W{1'b1}} : q_rnd[MEAN_W-1:0]);

    // Threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= '0;
        end else if (i_cfg_we) begin
            r_threshold <= i_cfg_wdata;
        end
    end

    // Track state: update per transaction, clear after the final sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.finish) begin
            r_have_prev  <= 1'b0;
            r_prev_speed <= '0;
            r_prev_time  <= '0;
            r_stopped    <= '0;
            r_moving     <= '0;
            r_wsum       <= '0;
            r_clip       <= 1'b0;
        end else begin
            if (i_cmd.load_item) begin
                r_have_prev  <= 1'b1;
                r_prev_speed <= speed_m;
                r_prev_time  <= time_m;
            end
            if (i_cmd.mul) begin
                if (r_mov) begin
                    r_moving <= mov_sum[SUM_W] ? {SUM_W{1'b1}} : mov_sum[SUM_W-1:0];
                    if (mov_sum[SUM_W]) begin
                        r_clip <= 1'b1;
                    end
                end else begin
                    r_stopped <= stop_sum[SUM_W] ? {SUM_W{1'b1}} : stop_sum[SUM_W-1:0];
                    if (stop_sum[SUM_W]) begin
                        r_clip <= 1'b1;
                    end
                end
            end
            if (i_cmd.acc) begin
                r_wsum <= wsum_sum[WSUM_W] ? {WSUM_W{1'b1}} : wsum_sum[WSUM_W-1:0];
                if (wsum_sum[WSUM_W]) begin
                    r_clip <= 1'b1;
                end
            end
        end
    end

    // Working registers for the interval being charged
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_last      <= i_last;
            r_step      <= r_have_prev ? step_c : '0;
            r_chg_speed <= r_prev_speed;
            r_mov       <= (r_prev_speed >= r_threshold);
        end
        if (i_cmd.mul) begin
            r_prod <= r_mov ? (r_step * r_chg_speed) : '0;
        end
    end

    // Divider: quotient shifts in as the dividend shifts out
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_div <= r_wsum;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_div <= {r_div[WSUM_W-2:0], div_ge};
            r_rem <= rem_sub[SUM_W-1:0];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_res_stopped <= r_stopped;
            r_res_moving  <= r_moving;
            r_res_mean    <= mean_c;
            r_res_sat     <= r_clip || mean_clip;
        end
    end

    assign o_stopped_seconds   = r_res_stopped;
    assign o_moving_seconds    = r_res_moving;
    assign o_mean_moving_speed = r_res_mean;
    assign o_saturated         = r_res_sat;

endmodule

`default_nettype wire

// ----- rtl/moving_speed_statistics_top.sv -----
// Top level of the moving speed statistics block
//
//  channel   direction  handshake                  payload
//  -------   ---------  -------------------------  ---------------------------------------
//  sample    in         i_in_valid / o_in_stall    i_speed, i_timestamp, i_last
//  result    out        o_out_valid / i_out_stall  o_stopped_seconds, o_moving_seconds,
//                                                  o_mean_moving_speed, o_saturated
//  config    in         i_cfg_we                   i_cfg_wdata (moving threshold)
//
// A sample passes through accept, multiply and time totals, then weighted-sum add.
// A final sample then loads the divider, runs the bit-serial divider, and
// rounds and loads the result.
// The result register holds one transaction; further samples are taken while it
// waits, and a following final sample waits at its round-and-load step until it is free.
// Synchronous active-low reset clears the threshold, track state and valid flags.
`default_nettype none

`include "moving_speed_statistics_top_macros.svh"

module moving_speed_statistics_top
    import mss_pkg::*;
#(
    parameter int SPEED_BITS = SPEED_BITS_DEF,
    parameter int TIME_BITS  = TIME_BITS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [THR_W-1:0] i_cfg_wdata,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire logic [SPD_W-1:0] i_speed,
    input  wire logic [TS_W-1:0]  i_timestamp,
    input  wire logic             i_last,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output logic [SUM_W-1:0]      o_stopped_seconds,
    output logic [SUM_W-1:0]      o_moving_seconds,
    output logic [MEAN_W-1:0]     o_mean_moving_speed,
    output logic                  o_saturated
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    mss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    mss_dp #(
        .SPEED_BITS (SPEED_BITS),
        .TIME_BITS  (TIME_BITS)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_wdata         (i_cfg_wdata),
        .i_speed             (i_speed),
        .i_timestamp         (i_timestamp),
        .i_last              (i_last),
        .i_cmd               (cmd),
        .o_stat              (stat),
        .o_stopped_seconds   (o_stopped_seconds),
        .o_moving_seconds    (o_moving_seconds),
        .o_mean_moving_speed (o_mean_moving_speed),
        .o_saturated         (o_saturated)
    );

    // Assertions
    `MSS_ASSERT_SAME(a_finish_needs_free_out, i_clk, i_rst_n, cmd.finish, (!o_out_valid || !i_out_stall))
    `MSS_ASSERT_NEXT(a_finish_sets_valid, i_clk, i_rst_n, cmd.finish, o_out_valid)
    `MSS_ASSERT_NEXT(a_accept_then_busy, i_clk, i_rst_n, (i_in_valid && !o_in_stall), o_in_stall)
    `MSS_ASSERT_ALWAYS(a_one_command, i_clk, i_rst_n, $onehot0(cmd))
    `MSS_ASSERT_SAME(a_work_while_stalled, i_clk, i_rst_n, (cmd.mul || cmd.acc || cmd.div_step), o_in_stall)

endmodule

`default_nettype wire
